>>> rtl/core/asg_pkg.sv
// Shared types, register codes and fixed-point helpers for the spike generator.
package asg_pkg;

    localparam int FIB_IDX_W   = 6;
    localparam int FIB_IDX_LIM = 2 ** FIB_IDX_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int TALLY_W     = 7;

    localparam logic [TALLY_W-1:0] TALLY_MAX = 7'd127;
    localparam logic [15:0]        TICK_MAX  = 16'hFFFF;
    localparam logic [55:0]        Q24_HALF  = 56'h80_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIRECT_DRIVE = 3'd0,
        CFG_SAMPLE_SCALE = 3'd1,
        CFG_REFRACTORY   = 3'd2,
        CFG_PULSE_TICKS  = 3'd3,
        CFG_FIRST_A      = 3'd4,
        CFG_FIRST_B      = 3'd5,
        CFG_DECAY_A      = 3'd6,
        CFG_DECAY_B      = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic        direct_drive;
        logic [23:0] sample_scale;
        logic [15:0] refractory_ticks;
        logic [7:0]  pulse_ticks;
        logic [31:0] first_term_a;
        logic [31:0] first_term_b;
        logic [23:0] decay_factor_a;
        logic [23:0] decay_factor_b;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        direct_drive:     1'b1,
        sample_scale:     24'd168,
        refractory_ticks: 16'd75,
        pulse_ticks:      8'd1,
        first_term_a:     32'd83,
        first_term_b:     32'd84,
        decay_factor_a:   24'd16610284,
        decay_factor_b:   24'd16763800
    };

    // One memory entry per fibre.
    typedef struct packed {
        logic [15:0] ticks;
        logic [7:0]  pulse_left;
        logic [31:0] fast_term;
        logic [31:0] slow_term;
    } t_fib_state;

    // Status from the update stage back to the control logic.
    typedef struct packed {
        logic pulsing;
    } t_upd_flags;

    // Q0.24 scaling with round to nearest, halves up.
    function automatic logic [31:0] q24_scale(input logic [31:0] x, input logic [23:0] f);
        logic [55:0] prod;
        prod = {24'd0, x} * {32'd0, f};
        prod = prod + Q24_HALF;
        return prod[55:24];
    endfunction

endpackage

>>> rtl/core/asg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module asg_ram #(
    parameter int WIDTH = 88,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/asg_fibre_update.sv
// Per-fibre threshold, spike and pulse update for one item.
module asg_fibre_update
    import asg_pkg::*;
(
    input  t_cfg        i_cfg,
    input  t_fib_state  i_state,
    input  logic        i_fresh,
    input  logic        i_in_range,
    input  logic [31:0] i_drive,
    input  logic [23:0] i_random_value,
    output t_fib_state  o_state,
    output t_upd_flags  o_flags
);

    logic [16:0] fresh_ticks;
    t_fib_state  base;
    logic        eligible;
    logic [33:0] bar;
    logic        spike;
    logic [7:0]  pulse1;
    logic [15:0] ticks1;
    logic        pulsing;

    always_comb begin
        // Load a fibre seen for the first time as if just reset.
        fresh_ticks = {1'b0, i_cfg.refractory_ticks} + 17'd1;
        base        = i_state;
        if (i_fresh) begin
            base.ticks      = fresh_ticks[16] ? TICK_MAX : fresh_ticks[15:0];
            base.pulse_left = 8'd0;
            base.fast_term  = i_cfg.first_term_a;
            base.slow_term  = i_cfg.first_term_b;
        end

        eligible = base.ticks > i_cfg.refractory_ticks;
        bar      = {2'b00, base.fast_term} + {2'b00, base.slow_term}
                 + {10'd0, i_random_value};
        spike    = eligible && ({2'b00, i_drive} > bar);

        o_state = base;
        pulse1  = base.pulse_left;
        ticks1  = base.ticks;
        if (spike) begin
            ticks1            = 16'd0;
            pulse1            = (i_cfg.pulse_ticks == 8'd0) ? 8'd1 : i_cfg.pulse_ticks;
            o_state.fast_term = i_cfg.first_term_a;
            o_state.slow_term = i_cfg.first_term_b;
        end else if (eligible) begin
            o_state.fast_term = q24_scale(base.fast_term, i_cfg.decay_factor_a);
            o_state.slow_term = q24_scale(base.slow_term, i_cfg.decay_factor_b);
        end

        pulsing            = i_in_range && (pulse1 != 8'd0);
        o_state.pulse_left = pulsing ? pulse1 - 8'd1 : pulse1;
        o_state.ticks      = (ticks1 == TICK_MAX) ? ticks1 : ticks1 + 16'd1;

        o_flags.pulsing = pulsing;
    end

endmodule

>>> rtl/core/auditory_nerve_spike_generator.sv
// Top level of the auditory nerve spike generator: pipeline, state memory, tally.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | i_valid / o_ready    | i_fibre_index, i_sample_value,
//           |                      | i_random_value, i_last_fibre
//  out      | o_valid / i_ready    | o_active_fibres (only for last-fibre items)
//  config   | i_cfg_we             | i_cfg_index, i_cfg_data
//
// One item per cycle sustained unless the pipeline halts. An item reads its
// fibre entry at acceptance, forms its drive in stage 1 and updates the entry
// in stage 2; the result of a last-fibre item then passes from stage 2 into
// the output register. The read-modify-write loop through the state RAM sets
// the rate; two forwarding paths cover back-to-back items on the same fibre.
// Reset clears the fibre-used flags, the tally, the pipeline and the config
// registers at once; no clearing pass runs.
// The pipeline halts only when a last-fibre item reaches stage 2 while the
// output register still holds an item that is not taken.
module auditory_nerve_spike_generator
    import asg_pkg::*;
#(
    parameter int FIBRES = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [FIB_IDX_W-1:0]  i_fibre_index,
    input  logic [31:0]           i_sample_value,
    input  logic [23:0]           i_random_value,
    input  logic                  i_last_fibre,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [TALLY_W-1:0]    o_active_fibres
);

    // Only as many entries as the index field can reach.
    localparam int USED = (FIBRES < FIB_IDX_LIM) ? FIBRES : FIB_IDX_LIM;
    localparam int AW   = (USED > 1) ? $clog2(USED) : 1;
    localparam int SW   = $bits(t_fib_state);

    t_cfg r_cfg;

    // Stage 1: RAM data arrives.
    logic                 r_s1_valid;
    logic [AW-1:0]        r_s1_addr;
    logic                 r_s1_in_range;
    logic [31:0]          r_s1_sample;
    logic [23:0]          r_s1_rnd;
    logic                 r_s1_last;

    // Stage 2: update and write back.
    logic                 r_s2_valid;
    logic [AW-1:0]        r_s2_addr;
    logic                 r_s2_in_range;
    logic [31:0]          r_s2_drive;
    logic [23:0]          r_s2_rnd;
    logic                 r_s2_last;
    logic                 r_s2_fresh;
    t_fib_state           r_s2_state;

    // Last write, for the item whose read met that write.
    logic                 r_wb_valid;
    logic [AW-1:0]        r_wb_addr;
    t_fib_state           r_wb_state;

    logic [USED-1:0]      r_used;
    logic [TALLY_W-1:0]   r_tally;
    logic                 r_out_valid;
    logic [TALLY_W-1:0]   r_out_count;

    logic                 adv;
    logic                 accept;
    logic [FIB_IDX_W+AW-1:0] idx_wide;
    logic [AW-1:0]        in_addr;
    logic                 in_range;
    logic [SW-1:0]        ram_rdata;
    t_fib_state           ram_state;
    logic                 ram_we;
    logic [31:0]          s1_drive;
    t_fib_state           n_s2_state;
    logic                 n_s2_fresh;
    t_fib_state           upd_state;
    t_upd_flags           upd_flags;
    logic [TALLY_W-1:0]   tally_inc;

    // Halt only when a tally has nowhere to go.
    assign adv     = !(r_s2_valid && r_s2_last && r_out_valid && !i_ready);
    assign o_ready = adv;
    assign accept  = i_valid && adv;

    assign idx_wide = {{AW{1'b0}}, i_fibre_index};
    assign in_addr  = idx_wide[AW-1:0];
    assign in_range = ({{(32-FIB_IDX_W){1'b0}}, i_fibre_index} < 32'(USED));

    assign ram_we    = adv && r_s2_valid && r_s2_in_range;
    assign ram_state = t_fib_state'(ram_rdata);

    asg_ram #(
        .WIDTH (SW),
        .DEPTH (USED)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s2_addr),
        .i_wdata (upd_state),
        .i_re    (adv),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    assign s1_drive = r_cfg.direct_drive ? r_s1_sample
                                         : q24_scale(r_s1_sample, r_cfg.sample_scale);

    // Forward the newest copy of the entry: the one in stage 2 first, then the
    // write that landed on the same edge as this item's read.
    always_comb begin
        n_s2_state = ram_state;
        n_s2_fresh = !r_used[r_s1_addr];
        priority if (r_s2_valid && r_s2_in_range && r_s1_in_range
                     && (r_s2_addr == r_s1_addr)) begin
            n_s2_state = upd_state;
            n_s2_fresh = 1'b0;
        end else if (r_wb_valid && r_s1_in_range && (r_wb_addr == r_s1_addr)) begin
            n_s2_state = r_wb_state;
            n_s2_fresh = 1'b0;
        end
    end

    asg_fibre_update u_update (
        .i_cfg          (r_cfg),
        .i_state        (r_s2_state),
        .i_fresh        (r_s2_fresh),
        .i_in_range     (r_s2_in_range),
        .i_drive        (r_s2_drive),
        .i_random_value (r_s2_rnd),
        .o_state        (upd_state),
        .o_flags        (upd_flags)
    );

    // Saturate the tally; the emitted count includes this item.
    assign tally_inc = (upd_flags.pulsing && (r_tally != TALLY_MAX)) ? r_tally + 7'd1
                                                                    : r_tally;

    // Config registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DIRECT_DRIVE: r_cfg.direct_drive     <= i_cfg_data[0];
                CFG_SAMPLE_SCALE: r_cfg.sample_scale     <= i_cfg_data[23:0];
                CFG_REFRACTORY:   r_cfg.refractory_ticks <= i_cfg_data[15:0];
                CFG_PULSE_TICKS:  r_cfg.pulse_ticks      <= i_cfg_data[7:0];
                CFG_FIRST_A:      r_cfg.first_term_a     <= i_cfg_data;
                CFG_FIRST_B:      r_cfg.first_term_b     <= i_cfg_data;
                CFG_DECAY_A:      r_cfg.decay_factor_a   <= i_cfg_data[23:0];
                CFG_DECAY_B:      r_cfg.decay_factor_b   <= i_cfg_data[23:0];
                default:          r_cfg                  <= r_cfg;
            endcase
        end
    end

    // Pipeline control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_wb_valid  <= 1'b0;
            r_used      <= '0;
            r_tally     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_s1_valid <= accept;
                r_s2_valid <= r_s1_valid;
                r_wb_valid <= ram_we;
                if (ram_we) begin
                    r_used[r_s2_addr] <= 1'b1;
                end
                if (r_s2_valid) begin
                    r_tally <= r_s2_last ? '0 : tally_inc;
                end
            end
            if (adv && r_s2_valid && r_s2_last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_addr     <= in_addr;
            r_s1_in_range <= in_range;
            r_s1_sample   <= i_sample_value;
            r_s1_rnd      <= i_random_value;
            r_s1_last     <= i_last_fibre;

            r_s2_addr     <= r_s1_addr;
            r_s2_in_range <= r_s1_in_range;
            r_s2_drive    <= s1_drive;
            r_s2_rnd      <= r_s1_rnd;
            r_s2_last     <= r_s1_last;
            r_s2_fresh    <= n_s2_fresh;
            r_s2_state    <= n_s2_state;

            r_wb_addr     <= r_s2_addr;
            r_wb_state    <= upd_state;

            if (r_s2_valid && r_s2_last) begin
                r_out_count <= tally_inc;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_active_fibres = r_out_count;

endmodule
